### design/sss_pkg.sv
package sss_pkg;

  // Default sizes of the stores.
  localparam int FEATURE_COUNT_DEF = 65536;
  localparam int MAX_NONZEROS_DEF  = 256;

  // Field and datapath widths fixed by the data formats.
  localparam int INDEX_W  = 16;
  localparam int VALUE_W  = 16;
  localparam int WEIGHT_W = 32;
  localparam int DEGREE_W = 24;
  localparam int RATE_W   = 16;
  localparam int ACC_W    = 48;
  localparam int DIV_STEPS = 32;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd32768;

  // Input item codes.
  typedef enum logic [1:0] {
    KIND_DEGREE  = 2'd0,
    KIND_TRAIN   = 2'd1,
    KIND_PREDICT = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  // Result codes.
  typedef enum logic [1:0] {
    RES_TRAIN   = 2'd0,
    RES_PREDICT = 2'd1,
    RES_CLEAR   = 2'd2
  } res_kind_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DEGREE,
    OP_LOAD,
    OP_CLR,
    OP_MAC,
    OP_ACC,
    OP_DECIDE,
    OP_EMIT,
    OP_BUF_RD,
    OP_ENT,
    OP_HINGE_WR,
    OP_SHR_MUL,
    OP_SHR_NUM,
    OP_DIV,
    OP_SHR_WR
  } dp_op_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_EL_MAC,
    ST_EL_ACC,
    ST_DECIDE,
    ST_H_BUF,
    ST_H_ENT,
    ST_H_WR,
    ST_S_BUF,
    ST_S_ENT,
    ST_S_MUL,
    ST_S_NUM,
    ST_S_DIV,
    ST_S_WR,
    ST_EMIT
  } ctrl_state_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic last;
    logic train;
    logic hinge;
    logic has_elems;
    logic walk_last;
    logic skip;
    logic div_done;
    logic clr_last;
  } sts_t;

endpackage

### design/sss_ram.sv
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sss_dp.sv
module sss_dp #(
  parameter int FEATURE_COUNT = sss_pkg::FEATURE_COUNT_DEF,
  parameter int MAX_NONZEROS  = sss_pkg::MAX_NONZEROS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sss_pkg::dp_op_t               op,
  output sss_pkg::sts_t                 sts,
  input  logic [1:0]                    in_kind,
  input  logic [15:0]                   in_feature_index,
  input  logic signed [15:0]            in_feature_value,
  input  logic                          in_label_positive,
  input  logic [23:0]                   in_degree_count,
  input  logic                          in_last_element,
  input  logic                          cfg_we,
  input  logic [15:0]                   cfg_wdata,
  output logic                          out_valid,
  output logic [1:0]                    out_result_kind,
  output logic signed [31:0]            out_score,
  output logic                          out_hinge_active,
  output logic                          out_prediction_correct
);
  import sss_pkg::*;

  localparam int WAW = $clog2(FEATURE_COUNT);
  localparam int BAW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int CW  = $clog2(MAX_NONZEROS + 1);
  localparam int DCW = $clog2(DIV_STEPS);
  localparam logic [CW-1:0]  COUNT_MAX = CW'(MAX_NONZEROS);
  localparam logic [WAW-1:0] CLR_LAST  = WAW'(FEATURE_COUNT - 1);
  localparam logic [DCW-1:0] DIV_LAST  = DCW'(DIV_STEPS - 1);
  localparam logic signed [ACC_W-1:0] ONE_Q24 = 48'sd16777216;

  function automatic logic [WEIGHT_W-1:0] sat32(input logic signed [33:0] v);
    logic [WEIGHT_W-1:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic idx_ok(input logic [INDEX_W-1:0] idx);
    return {16'd0, idx} < 32'(FEATURE_COUNT);
  endfunction

  // Control registers.
  logic [RATE_W-1:0]       rate_r;
  logic [CW-1:0]           count_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [WAW-1:0]          clr_addr_r;
  logic                    clr_deg_r;
  logic [CW-1:0]           walk_r;
  logic [DCW-1:0]          div_cnt_r;
  logic                    out_valid_r;

  // Payload registers.
  logic [INDEX_W-1:0]        idx_r;
  logic signed [VALUE_W-1:0] val_r;
  logic                      pos_r;
  logic                      last_r;
  logic [1:0]                kind_r;
  logic                      ok_r;
  logic signed [47:0]        prod_r;
  logic signed [WEIGHT_W-1:0] score_r;
  logic                      hinge_r;
  logic                      correct_r;
  logic [INDEX_W-1:0]        ent_idx_r;
  logic                      ent_ok_r;
  logic signed [28:0]        inc_r;
  logic [47:0]               mag_r;
  logic signed [WEIGHT_W-1:0] wcur_r;
  logic [DEGREE_W-1:0]       deg_r;
  logic [31:0]               quo_r;
  logic [DEGREE_W-1:0]       rem_r;
  logic [1:0]                res_kind_r;
  logic signed [31:0]        res_score_r;
  logic                      res_hinge_r;
  logic                      res_correct_r;

  // Memory ports.
  logic                 w_we, d_we, b_we;
  logic [WAW-1:0]       w_waddr, w_raddr, d_waddr, d_raddr;
  logic [BAW-1:0]       b_waddr, b_raddr;
  logic [WEIGHT_W-1:0]  w_wdata, w_rdata;
  logic [DEGREE_W-1:0]  d_wdata, d_rdata;
  logic [31:0]          b_wdata, b_rdata;

  // Combinational values.
  logic                      walk_last;
  logic                      hinge_c, correct_c;
  logic signed [WEIGHT_W-1:0] score_c;
  logic signed [48:0]        prod_rnd;
  logic signed [32:0]        rate_prod;
  logic signed [33:0]        inc_rnd;
  logic signed [28:0]        inc_c;
  logic [WEIGHT_W-1:0]       w_abs;
  logic [48:0]               num_c;
  logic [DEGREE_W:0]         rem_sh;
  logic                      q_bit;
  logic signed [33:0]        hinge_sum, shr_sum;
  logic                      shr_skip;

  sss_ram #(.WIDTH(WEIGHT_W), .DEPTH(FEATURE_COUNT)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  sss_ram #(.WIDTH(DEGREE_W), .DEPTH(FEATURE_COUNT)) u_degree (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  sss_ram #(.WIDTH(32), .DEPTH(MAX_NONZEROS)) u_buffer (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // Rounding of the element product and the hinge increment.
  assign prod_rnd  = ($signed({prod_r[47], prod_r}) + 49'sd8192) >>> 14;
  assign rate_prod = $signed(b_rdata[15:0]) * $signed({1'b0, rate_r});
  assign inc_rnd   = ($signed({rate_prod[32], rate_prod}) + 34'sd32) >>> 6;
  assign inc_c     = pos_r ? inc_rnd[28:0] : -inc_rnd[28:0];

  // Hinge and sign tests on the unsaturated sum; the score is clamped to 34 bits first.
  assign hinge_c   = pos_r ? (acc_r < ONE_Q24) : (acc_r > -ONE_Q24);
  assign correct_c = pos_r ? (acc_r > 48'sd0) : (acc_r < 48'sd0);
  assign score_c   = sat32((acc_r > 48'sd8589934591) ? 34'sd8589934591 :
                           (acc_r < -48'sd8589934592) ? -34'sd8589934592 :
                           $signed(acc_r[33:0]));

  // Weight updates.
  assign hinge_sum = $signed({{2{w_rdata[31]}}, w_rdata}) + $signed({{5{inc_r[28]}}, inc_r});
  assign shr_sum   = wcur_r[31] ?
                     $signed({{2{wcur_r[31]}}, wcur_r}) + $signed({2'b00, quo_r}) :
                     $signed({{2{wcur_r[31]}}, wcur_r}) - $signed({2'b00, quo_r});
  assign w_abs     = w_rdata[31] ? (~w_rdata + 32'd1) : w_rdata;
  assign num_c     = {1'b0, mag_r} + ({25'd0, deg_r} << 15);
  assign shr_skip  = !ent_ok_r || (d_rdata == '0);

  // One restoring division step.
  assign rem_sh = {rem_r, quo_r[31]};
  assign q_bit  = rem_sh >= {1'b0, deg_r};

  assign walk_last = (walk_r + CW'(1)) == count_r;

  // Memory port selection.
  always_comb begin
    w_we    = 1'b0;
    w_waddr = WAW'(ent_idx_r);
    w_wdata = '0;
    unique case (op)
      OP_CLR: begin
        w_we    = 1'b1;
        w_waddr = clr_addr_r;
      end
      OP_HINGE_WR: begin
        w_we    = ent_ok_r;
        w_wdata = sat32(hinge_sum);
      end
      OP_SHR_WR: begin
        w_we    = ent_ok_r;
        w_wdata = sat32(shr_sum);
      end
      default: begin
        w_we = 1'b0;
      end
    endcase
    w_raddr = (op == OP_ENT) ? WAW'(b_rdata[31:16]) : WAW'(in_feature_index);

    d_we    = (op == OP_CLR && clr_deg_r) || (op == OP_DEGREE && idx_ok(in_feature_index));
    d_waddr = (op == OP_CLR) ? clr_addr_r : WAW'(in_feature_index);
    d_wdata = (op == OP_CLR) ? '0 : in_degree_count;
    d_raddr = WAW'(b_rdata[31:16]);

    b_we    = (op == OP_ACC);
    b_waddr = BAW'(count_r);
    b_wdata = {idx_r, val_r};
    b_raddr = BAW'(walk_r);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= RATE_RESET;
      count_r     <= '0;
      acc_r       <= '0;
      clr_addr_r  <= '0;
      clr_deg_r   <= 1'b1;
      walk_r      <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_wdata;
      end
      out_valid_r <= (op == OP_EMIT);
      case (op)
        OP_CLR: begin
          if (clr_addr_r == CLR_LAST) begin
            clr_addr_r <= '0;
            clr_deg_r  <= 1'b0;
          end else begin
            clr_addr_r <= clr_addr_r + WAW'(1);
          end
        end
        OP_ACC: begin
          count_r <= count_r + CW'(1);
          acc_r   <= acc_r + prod_rnd[47:0];
        end
        OP_DECIDE: walk_r <= '0;
        OP_EMIT: begin
          count_r <= '0;
          acc_r   <= '0;
        end
        OP_HINGE_WR, OP_SHR_WR: walk_r <= walk_last ? '0 : walk_r + CW'(1);
        OP_SHR_MUL: begin
          if (shr_skip) begin
            walk_r <= walk_last ? '0 : walk_r + CW'(1);
          end
        end
        OP_SHR_NUM: div_cnt_r <= '0;
        OP_DIV:     div_cnt_r <= div_cnt_r + DCW'(1);
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        idx_r  <= in_feature_index;
        val_r  <= in_feature_value;
        pos_r  <= in_label_positive;
        last_r <= in_last_element;
        kind_r <= in_kind;
        ok_r   <= idx_ok(in_feature_index);
      end
      OP_MAC: prod_r <= val_r * $signed(ok_r ? w_rdata : 32'd0);
      OP_DECIDE: begin
        score_r   <= score_c;
        hinge_r   <= hinge_c;
        correct_r <= correct_c;
      end
      OP_ENT: begin
        ent_idx_r <= b_rdata[31:16];
        ent_ok_r  <= idx_ok(b_rdata[31:16]);
        inc_r     <= inc_c;
      end
      OP_SHR_MUL: begin
        mag_r  <= w_abs * rate_r;
        wcur_r <= w_rdata;
        deg_r  <= d_rdata;
      end
      OP_SHR_NUM: begin
        quo_r <= num_c[47:16];
        rem_r <= '0;
      end
      OP_DIV: begin
        quo_r <= {quo_r[30:0], q_bit};
        rem_r <= q_bit ? DEGREE_W'(rem_sh - {1'b0, deg_r}) : rem_sh[DEGREE_W-1:0];
      end
      OP_EMIT: begin
        if (kind_r == KIND_CLEAR) begin
          res_kind_r    <= RES_CLEAR;
          res_score_r   <= '0;
          res_hinge_r   <= 1'b0;
          res_correct_r <= 1'b0;
        end else begin
          res_kind_r    <= (kind_r == KIND_TRAIN) ? RES_TRAIN : RES_PREDICT;
          res_score_r   <= score_r;
          res_hinge_r   <= hinge_r;
          res_correct_r <= correct_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Status to the controller.
  always_comb begin
    sts.full      = (count_r == COUNT_MAX);
    sts.last      = last_r;
    sts.train     = (kind_r == KIND_TRAIN);
    sts.hinge     = hinge_c;
    sts.has_elems = (count_r != '0);
    sts.walk_last = walk_last;
    sts.skip      = shr_skip;
    sts.div_done  = (div_cnt_r == DIV_LAST);
    sts.clr_last  = (clr_addr_r == CLR_LAST);
  end

  assign out_valid              = out_valid_r;
  assign out_result_kind        = res_kind_r;
  assign out_score              = res_score_r;
  assign out_hinge_active       = res_hinge_r;
  assign out_prediction_correct = res_correct_r;

endmodule

### design/sss_ctrl.sv
module sss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_kind,
  input  logic             in_last_element,
  input  sss_pkg::sts_t    sts,
  output sss_pkg::dp_op_t  op,
  output logic             busy
);
  import sss_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        report_r, report_nxt;

  // State register; reset starts the clearing pass over both stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      report_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      report_r <= report_nxt;
    end
  end

  // Next state and datapath operation.
  always_comb begin
    state_nxt  = state_r;
    report_nxt = report_r;
    op         = OP_IDLE;
    unique case (state_r)
      ST_CLR: begin
        op = OP_CLR;
        if (sts.clr_last) begin
          state_nxt = report_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (in_kind)
            KIND_DEGREE: op = OP_DEGREE;
            KIND_CLEAR: begin
              op         = OP_LOAD;
              report_nxt = 1'b1;
              state_nxt  = ST_CLR;
            end
            default: begin
              op = OP_LOAD;
              if (!sts.full) begin
                state_nxt = ST_EL_MAC;
              end else if (in_last_element) begin
                state_nxt = ST_DECIDE;
              end
            end
          endcase
        end
      end
      ST_EL_MAC: begin
        op        = OP_MAC;
        state_nxt = ST_EL_ACC;
      end
      ST_EL_ACC: begin
        op        = OP_ACC;
        state_nxt = sts.last ? ST_DECIDE : ST_IDLE;
      end
      ST_DECIDE: begin
        op = OP_DECIDE;
        if (sts.train && sts.has_elems) begin
          state_nxt = sts.hinge ? ST_H_BUF : ST_S_BUF;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_H_BUF: begin
        op        = OP_BUF_RD;
        state_nxt = ST_H_ENT;
      end
      ST_H_ENT: begin
        op        = OP_ENT;
        state_nxt = ST_H_WR;
      end
      ST_H_WR: begin
        op        = OP_HINGE_WR;
        state_nxt = sts.walk_last ? ST_S_BUF : ST_H_BUF;
      end
      ST_S_BUF: begin
        op        = OP_BUF_RD;
        state_nxt = ST_S_ENT;
      end
      ST_S_ENT: begin
        op        = OP_ENT;
        state_nxt = ST_S_MUL;
      end
      ST_S_MUL: begin
        op = OP_SHR_MUL;
        if (sts.skip) begin
          state_nxt = sts.walk_last ? ST_EMIT : ST_S_BUF;
        end else begin
          state_nxt = ST_S_NUM;
        end
      end
      ST_S_NUM: begin
        op        = OP_SHR_NUM;
        state_nxt = ST_S_DIV;
      end
      ST_S_DIV: begin
        op = OP_DIV;
        if (sts.div_done) begin
          state_nxt = ST_S_WR;
        end
      end
      ST_S_WR: begin
        op        = OP_SHR_WR;
        state_nxt = sts.walk_last ? ST_EMIT : ST_S_BUF;
      end
      ST_EMIT: begin
        op         = OP_EMIT;
        report_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### design/sparse_svm_sgd_step.sv
// Sparse linear SVM trainer. An element beat is taken when start is high and busy is low;
// an element of a point goes through weight read, multiply and accumulate; one beyond the
// buffer depth is dropped. After the last element come the decide and emit states, and the
// one-cycle out_valid strobe follows. Between the two a training point walks its buffered
// elements for the hinge update when it applies (buffer read, entry, write), then for the
// shrink (buffer read, entry, multiply, numerator, 32-step serial divider, write; a zero
// degree or out-of-range index skips the rest). A degree load leaves busy low. Reset sweeps
// the weight and degree stores, and a clear the weight store, one entry a cycle; a clear
// then emits its result before busy falls. Results cannot be held off by the receiver.
module sparse_svm_sgd_step #(
  parameter int FEATURE_COUNT = sss_pkg::FEATURE_COUNT_DEF,
  parameter int MAX_NONZEROS  = sss_pkg::MAX_NONZEROS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [15:0]        in_feature_index,
  input  logic signed [15:0] in_feature_value,
  input  logic               in_label_positive,
  input  logic [23:0]        in_degree_count,
  input  logic               in_last_element,
  output logic               out_valid,
  output logic [1:0]         out_result_kind,
  output logic signed [31:0] out_score,
  output logic               out_hinge_active,
  output logic               out_prediction_correct,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import sss_pkg::*;

  dp_op_t op;
  sts_t   sts;

  // Sequencer.
  sss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_kind(in_kind),
    .in_last_element(in_last_element), .sts(sts), .op(op), .busy(busy)
  );

  // Stores and arithmetic.
  sss_dp #(.FEATURE_COUNT(FEATURE_COUNT), .MAX_NONZEROS(MAX_NONZEROS)) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op), .sts(sts),
    .in_kind(in_kind), .in_feature_index(in_feature_index),
    .in_feature_value(in_feature_value), .in_label_positive(in_label_positive),
    .in_degree_count(in_degree_count), .in_last_element(in_last_element),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_result_kind(out_result_kind), .out_score(out_score),
    .out_hinge_active(out_hinge_active),
    .out_prediction_correct(out_prediction_correct)
  );

  // Result strobes never come back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result strobes");

  // A clear beat starts the sweep at once.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_CLEAR) |=> busy)
    else $error("clear beat did not start the sweep");

  // A degree beat finishes in its own cycle.
  a_degree_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_DEGREE) |=> !busy)
    else $error("degree beat held the block busy");

  // A clear result carries zero fields.
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RES_CLEAR) |->
      (out_score == 32'sd0 && !out_hinge_active && !out_prediction_correct))
    else $error("clear result with nonzero fields");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sss_pkg::*;

  localparam int NUM_FEATURES = 65536;
  localparam int BUF_DEPTH    = 256;
  localparam int QUIET_CYCLES = 8;
  localparam int STALL_LIMIT  = 400000;

  // One entry of the stimulus queue: either an element beat or a pause.
  typedef struct {
    bit                 pause;
    bit                 set_rate;
    logic [15:0]        rate;
    int                 idle_pct;
    kind_t              kind;
    logic [15:0]        idx;
    logic signed [15:0] val;
    logic               pos;
    logic [23:0]        deg;
    logic               last;
  } beat_t;

  typedef struct {
    res_kind_t          rk;
    logic signed [31:0] score;
    logic               hinge;
    logic               correct;
  } outcome_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_kind;
  logic [15:0]        in_feature_index;
  logic signed [15:0] in_feature_value;
  logic               in_label_positive;
  logic [23:0]        in_degree_count;
  logic               in_last_element;
  logic               out_valid;
  logic [1:0]         out_result_kind;
  logic signed [31:0] out_score;
  logic               out_hinge_active;
  logic               out_prediction_correct;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;

  beat_t    beat_q[$];
  outcome_t outcome_q[$];
  int       errors;
  int       quiet;
  int       idle_pct;
  bit       rate_pending;
  logic [15:0] rate_next;
  int       stall_cycles;

  // Shadow state of the trainer.
  int          weight_mem[NUM_FEATURES];
  logic [23:0] degree_mem[NUM_FEATURES];
  logic [15:0] pt_idx[BUF_DEPTH];
  logic signed [15:0] pt_val[BUF_DEPTH];
  int          pt_count;
  longint      dot_sum;
  logic [15:0] step_rate;

  sparse_svm_sgd_step u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_feature_index(in_feature_index),
    .in_feature_value(in_feature_value), .in_label_positive(in_label_positive),
    .in_degree_count(in_degree_count), .in_last_element(in_last_element),
    .out_valid(out_valid), .out_result_kind(out_result_kind), .out_score(out_score),
    .out_hinge_active(out_hinge_active), .out_prediction_correct(out_prediction_correct),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Update the shadow state for one accepted beat and queue its result, if any.
  task automatic train_step(beat_t b);
    outcome_t o;
    longint   acc;
    longint   inc;
    longint   w;
    longint   d;
    longint   mag;
    longint   q;
    bit       hinge;
    bit       correct;
    int       j;
    if (b.kind == KIND_DEGREE) begin
      degree_mem[b.idx] = b.deg;
      return;
    end
    if (b.kind == KIND_CLEAR) begin
      foreach (weight_mem[k]) weight_mem[k] = 0;
      pt_count = 0;
      dot_sum = 0;
      o.rk = RES_CLEAR; o.score = 0; o.hinge = 0; o.correct = 0;
      outcome_q.insert(outcome_q.size(), o);
      return;
    end
    // Elements past the buffer depth are dropped.
    if (pt_count < BUF_DEPTH) begin
      pt_idx[pt_count] = b.idx;
      pt_val[pt_count] = b.val;
      pt_count++;
      dot_sum += round_half_up(longint'(b.val) * longint'(weight_mem[b.idx]), 14);
    end
    if (!b.last) return;
    acc = dot_sum;
    hinge = b.pos ? (acc < (longint'(1) <<< 24)) : (-acc < (longint'(1) <<< 24));
    correct = b.pos ? (acc > 0) : (acc < 0);
    if (b.kind == KIND_TRAIN) begin
      if (hinge) begin
        for (int i = 0; i < pt_count; i++) begin
          j = pt_idx[i];
          inc = round_half_up(longint'(pt_val[i]) * longint'(step_rate), 6);
          if (!b.pos) inc = -inc;
          weight_mem[j] = clamp32(longint'(weight_mem[j]) + inc);
        end
      end
      // Shrink pass; a zero degree leaves the weight alone.
      for (int i = 0; i < pt_count; i++) begin
        j = pt_idx[i];
        if (degree_mem[j] != 0) begin
          w = weight_mem[j];
          d = longint'(degree_mem[j]) <<< 16;
          mag = (w < 0 ? -w : w) * longint'(step_rate);
          q = (mag + d / 2) / d;
          weight_mem[j] = clamp32(w < 0 ? w + q : w - q);
        end
      end
    end
    pt_count = 0;
    dot_sum = 0;
    o.rk = (b.kind == KIND_TRAIN) ? RES_TRAIN : RES_PREDICT;
    o.score = clamp32(acc);
    o.hinge = hinge;
    o.correct = correct;
    outcome_q.insert(outcome_q.size(), o);
  endtask

  // Driver: takes beats from the queue, holds each until accepted.
  always @(posedge clk) begin
    beat_t b;
    bit    nxt_start;
    bit    nxt_we;
    if (rst_n) begin
      if (cfg_we) step_rate = cfg_wdata;
      nxt_start = start && busy;
      nxt_we = 1'b0;
      if (start && !busy) begin
        b.kind = kind_t'(in_kind);
        b.idx = in_feature_index;
        b.val = in_feature_value;
        b.pos = in_label_positive;
        b.deg = in_degree_count;
        b.last = in_last_element;
        train_step(b);
      end
      if (!nxt_start) begin
        if (quiet > 0) begin
          // Pause until the block is idle and every result is in.
          if (busy || outcome_q.size() != 0) quiet <= QUIET_CYCLES;
          else begin
            quiet <= quiet - 1;
            if (quiet == 1 && rate_pending) begin
              nxt_we = 1'b1;
              cfg_wdata <= rate_next;
              rate_pending = 1'b0;
            end
          end
        end else if (beat_q.size() != 0) begin
          b = beat_q[0];
          if (b.pause) begin
            void'(beat_q.pop_front());
            quiet <= QUIET_CYCLES;
            rate_pending = b.set_rate;
            rate_next = b.rate;
            idle_pct = b.idle_pct;
          end else if ($urandom_range(99) >= idle_pct) begin
            void'(beat_q.pop_front());
            nxt_start = 1'b1;
            in_kind <= b.kind;
            in_feature_index <= b.idx;
            in_feature_value <= b.val;
            in_label_positive <= b.pos;
            in_degree_count <= b.deg;
            in_last_element <= b.last;
          end
        end
      end
      start <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // Monitor: each strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    outcome_t o;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        o = outcome_q.pop_front();
        if (out_result_kind !== o.rk)
          report_mismatch($sformatf("result_kind %0d, expected %0d", out_result_kind, o.rk));
        if (out_score !== o.score)
          report_mismatch($sformatf("score %0d, expected %0d", out_score, o.score));
        if (out_hinge_active !== o.hinge)
          report_mismatch($sformatf("hinge_active %0b, expected %0b",
                                    out_hinge_active, o.hinge));
        if (out_prediction_correct !== o.correct)
          report_mismatch($sformatf("prediction_correct %0b, expected %0b",
                                    out_prediction_correct, o.correct));
      end
    end
  end

  // Watchdog on cycles in which no beat moves in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_beat(kind_t k, int idx, int val, bit pos, int deg, bit last);
    beat_t b;
    b.pause = 0; b.set_rate = 0; b.rate = 0; b.idle_pct = 0;
    b.kind = k; b.idx = 16'(idx); b.val = 16'(val); b.pos = pos; b.deg = 24'(deg);
    b.last = last;
    beat_q.insert(beat_q.size(), b);
  endtask

  task automatic add_pause(bit set_rate, int rate, int pct);
    beat_t b;
    b.kind = KIND_DEGREE; b.idx = '0; b.val = '0; b.pos = 1'b0; b.deg = '0; b.last = 1'b0;
    b.pause = 1; b.set_rate = set_rate; b.rate = 16'(rate); b.idle_pct = pct;
    beat_q.insert(beat_q.size(), b);
  endtask

  function automatic int pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(15);
    if (r < 85) return ($urandom_range(1) != 0) ? 65535 : 0;
    return $urandom_range(65535);
  endfunction

  function automatic int pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 32767;
    if (r < 8) return -32768;
    if (r < 12) return ($urandom_range(1) != 0) ? 1 : -1;
    return $signed(16'($urandom_range(65535)));
  endfunction

  function automatic int pick_degree();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 20) return 24'hffffff;
    if (r < 80) return $urandom_range(1, 8);
    return $urandom_range(24'hffffff);
  endfunction

  function automatic int idle_pct_of(int ph);
    return (ph == 0) ? 0 : (ph == 1) ? 87 : 34;
  endfunction

  // Stimulus, then the wait for the last results.
  initial begin
    int    total;
    int    len;
    int    r;
    bit    pos;
    kind_t k;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_kind = KIND_DEGREE;
    in_feature_index = '0;
    in_feature_value = '0;
    in_label_positive = 1'b0;
    in_degree_count = '0;
    in_last_element = 1'b0;
    errors = 0;
    quiet = 0;
    idle_pct = 0;
    rate_pending = 0;
    rate_next = '0;
    stall_cycles = 0;
    pt_count = 0;
    dot_sum = 0;
    step_rate = RATE_RESET;
    foreach (weight_mem[i]) weight_mem[i] = 0;
    foreach (degree_mem[i]) degree_mem[i] = '0;

    // Directed part: degree extremes, both point kinds, mixed points, clear, rate extremes.
    add_pause(0, 0, 0);
    add_beat(KIND_DEGREE, 0, 0, 0, 0, 0);
    add_beat(KIND_DEGREE, 65535, 0, 0, 24'hffffff, 0);
    add_beat(KIND_DEGREE, 3, 0, 0, 1, 0);
    add_beat(KIND_DEGREE, 5, 0, 0, 2, 0);
    add_beat(KIND_TRAIN, 3, 32767, 1, 0, 1);
    add_beat(KIND_TRAIN, 65535, -32768, 0, 0, 0);
    add_beat(KIND_TRAIN, 0, 1, 0, 0, 1);
    add_beat(KIND_PREDICT, 3, 32767, 1, 0, 1);
    add_beat(KIND_PREDICT, 3, -32768, 0, 0, 1);
    // A point whose last element switches the kind.
    add_beat(KIND_TRAIN, 5, 100, 1, 0, 0);
    add_beat(KIND_PREDICT, 3, 5, 0, 0, 1);
    // Degree load in the middle of a point, and a repeated index.
    add_beat(KIND_TRAIN, 5, 200, 1, 0, 0);
    add_beat(KIND_DEGREE, 5, 0, 0, 7, 0);
    add_beat(KIND_TRAIN, 5, -300, 1, 0, 1);
    add_beat(KIND_TRAIN, 3, 77, 1, 0, 0);
    add_beat(KIND_CLEAR, 0, 0, 0, 0, 0);
    add_beat(KIND_PREDICT, 3, 32767, 1, 0, 1);
    add_pause(1, 0, 0);
    add_beat(KIND_TRAIN, 3, 1000, 1, 0, 1);
    add_pause(1, 65535, 0);
    add_beat(KIND_TRAIN, 3, 1000, 0, 0, 1);
    // Overfilled point on one feature: saturates the weight and drops the overflow.
    for (int i = 0; i < 260; i++) add_beat(KIND_TRAIN, 6, 32767, 1, 0, i == 259);
    add_beat(KIND_PREDICT, 6, 32767, 1, 0, 1);
    add_beat(KIND_PREDICT, 6, -32768, 1, 0, 1);

    // Random part in three idling phases, rate rewritten between them.
    total = 0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: add_pause(1, $urandom_range(65535), 0);
        1: add_pause(1, 1, 87);
        default: add_pause(1, 32768 + $urandom_range(32767), 34);
      endcase
      while (total < 510 * (ph + 1)) begin
        r = $urandom_range(99);
        if (r < 12) begin
          add_beat(KIND_DEGREE, pick_index(), pick_value(), 1'($urandom_range(1)),
                   pick_degree(), 1'($urandom_range(1)));
          total++;
        end else if (r == 12 && $urandom_range(3) == 0) begin
          add_beat(KIND_CLEAR, pick_index(), pick_value(), 1'($urandom_range(1)),
                   $urandom_range(24'hffffff), 1'($urandom_range(1)));
          total++;
        end else begin
          k = ($urandom_range(99) < 55) ? KIND_TRAIN : KIND_PREDICT;
          pos = 1'($urandom_range(1));
          len = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 4) add_beat(KIND_DEGREE, pick_index(), 0, 0, pick_degree(), 0);
            if (r >= 4 && r < 7) k = (k == KIND_TRAIN) ? KIND_PREDICT : KIND_TRAIN;
            add_beat(k, pick_index(), pick_value(), pos, $urandom_range(24'hffffff),
                     i == len - 1);
            total++;
          end
        end
        // Now and then, wait for every result before going on.
        if ($urandom_range(99) == 0) add_pause(0, 0, idle_pct_of(ph));
      end
    end
    add_pause(1, 65535, 0);
    for (int i = 0; i < 8; i++) add_beat(KIND_TRAIN, i, 32767, 1, 0, i == 7);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (beat_q.size() != 0 || quiet != 0 || start || outcome_q.size() != 0 || busy)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
design/sss_pkg.sv
design/sss_ram.sv
design/sss_dp.sv
design/sss_ctrl.sv
design/sparse_svm_sgd_step.sv
tb/testbench.sv
